// ===== rtl/core/mtep_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the MIDI track event parser.
// Depends on nothing; the top level and mtep_parse refer to it by scoped names.
package mtep_pkg;

  // Longest variable-length quantity, in bytes, before an overflow is flagged.
  localparam int unsigned VARLEN_MAX = 4;
  localparam int unsigned VCOUNT_W = 3;

  // Parser phases.
  localparam logic [2:0] PH_DELTA  = 3'd0;
  localparam logic [2:0] PH_STATUS = 3'd1;
  localparam logic [2:0] PH_DATA1  = 3'd2;
  localparam logic [2:0] PH_DATA2  = 3'd3;
  localparam logic [2:0] PH_MTYPE  = 3'd4;
  localparam logic [2:0] PH_MLEN   = 3'd5;
  localparam logic [2:0] PH_MSKIP  = 3'd6;
  localparam logic [2:0] PH_SYSEX  = 3'd7;

  // Record kinds.
  localparam logic [2:0] KIND_CHANNEL  = 3'd0;
  localparam logic [2:0] KIND_SYSTEM   = 3'd1;
  localparam logic [2:0] KIND_META     = 3'd2;
  localparam logic [2:0] KIND_SYSEX    = 3'd3;
  localparam logic [2:0] KIND_STRAY    = 3'd4;
  localparam logic [2:0] KIND_OVERFLOW = 3'd5;
  localparam logic [2:0] KIND_TRUNC    = 3'd6;

  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX = 8'hF0;
  localparam logic [7:0] STATUS_SYS   = 8'hF0;
  localparam logic [7:0] STATUS_RT    = 8'hF8;

  typedef struct packed {
    logic [2:0]          phase;
    logic [7:0]          running_status;
    logic [7:0]          current_status;
    logic [27:0]         acc;
    logic [VCOUNT_W-1:0] vcount;
    logic [27:0]         held_delta;
    logic [6:0]          held_first;
    logic [7:0]          held_meta_type;
    logic [27:0]         skip;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [27:0] delta_time;
    logic [7:0]  status;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [1:0]  data_count;
    logic [7:0]  meta_type;
    logic [27:0] meta_length;
  } event_rec_t;

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] data_needed(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd2;
    if (s[7:4] == 4'hC || s[7:4] == 4'hD) begin
      n = 2'd1;
    end else if (s[7:4] == 4'hF) begin
      if (s[3:0] == 4'h1 || s[3:0] == 4'h3) begin
        n = 2'd1;
      end else if (s[3:0] == 4'h2) begin
        n = 2'd2;
      end else begin
        n = 2'd0;
      end
    end
    return n;
  endfunction

  function automatic logic [2:0] kind_of(input logic [7:0] s);
    return (s < STATUS_SYS) ? KIND_CHANNEL : KIND_SYSTEM;
  endfunction

endpackage

// ===== rtl/core/mtep_byte_if.sv =====
`timescale 1ns / 1ps
// Request channel that carries track bytes into the parser.
// Depends on nothing.
interface mtep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_last;

  modport source (output valid, output track_byte, output track_last, input ready);
  modport sink (input valid, input track_byte, input track_last, output ready);
endinterface

// ===== rtl/core/mtep_event_if.sv =====
`timescale 1ns / 1ps
// Request channel that carries parsed event records out of the parser.
// Depends on nothing.
interface mtep_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [27:0] delta_time;
  logic [7:0]  status;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [1:0]  data_count;
  logic [7:0]  meta_type;
  logic [27:0] meta_length;

  modport source (output valid, output kind, output delta_time, output status,
                  output first_data, output second_data, output data_count,
                  output meta_type, output meta_length, input ready);
  modport sink (input valid, input kind, input delta_time, input status,
                input first_data, input second_data, input data_count,
                input meta_type, input meta_length, output ready);
endinterface

// ===== rtl/core/midi_track_event_parser_top.sv =====
`timescale 1ns / 1ps
// Top level of the MIDI track event parser: parser state, result register, handshakes.
// Depends on mtep_pkg, mtep_byte_if, mtep_event_if and mtep_parse.
//
//   Channel | Dir | Request payload
//   --------+-----+--------------------------------------------------------------
//   track   | in  | track_byte[7:0], track_last
//   events  | out | kind, delta_time, status, first_data, second_data,
//           |     | data_count, meta_type, meta_length
//
// Each accepted track byte is parsed in the cycle it is accepted: the parser
// state and the result register are updated at that same clock edge, so the
// block takes one byte per cycle unless stalled, and a record appears in the
// cycle after the byte that completes it. The single result register sets the
// rate: a byte is taken whenever that register is empty or its record is
// leaving in the same cycle. Reset (rst, synchronous, active high) clears the
// parser state, running status included, and empties the result register.
module midi_track_event_parser_top (
  input  logic         clk,
  input  logic         rst,
  mtep_byte_if.sink    track,
  mtep_event_if.source events
);

  mtep_pkg::parse_state_t st;
  mtep_pkg::parse_state_t st_next;
  mtep_pkg::event_rec_t   rec;
  mtep_pkg::event_rec_t   out_rec;
  logic                   emit;
  logic                   out_valid;
  logic                   take;

  // The parser is purely combinational on the current state and the offered byte.
  mtep_parse u_parse (
    .st         (st),
    .track_byte (track.track_byte),
    .track_last (track.track_last),
    .st_next    (st_next),
    .emit       (emit),
    .rec        (rec)
  );

  // A new byte can come in while the held record is being taken downstream.
  assign track.ready = !out_valid || events.ready;
  assign take        = track.valid && track.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload register needs no reset; it is only loaded alongside out_valid.
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_rec <= rec;
    end
  end

  assign events.valid       = out_valid;
  assign events.kind        = out_rec.kind;
  assign events.delta_time  = out_rec.delta_time;
  assign events.status      = out_rec.status;
  assign events.first_data  = out_rec.first_data;
  assign events.second_data = out_rec.second_data;
  assign events.data_count  = out_rec.data_count;
  assign events.meta_type   = out_rec.meta_type;
  assign events.meta_length = out_rec.meta_length;

  // Channel records always carry at least one data byte.
  a_channel_has_data: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.kind == mtep_pkg::KIND_CHANNEL |-> events.data_count != 2'd0)
    else $error("channel record without data bytes");

  // Meta records always report the meta status.
  a_meta_status: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.kind == mtep_pkg::KIND_META |-> events.status == mtep_pkg::STATUS_META)
    else $error("meta record with wrong status");

  // The last byte of a track returns the parser to its idle state.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    track.valid && track.ready && track.track_last |=>
      st.phase == mtep_pkg::PH_DELTA && st.running_status == 8'd0)
    else $error("parser not reset after last track byte");

  // With an empty result register the block must be taking bytes.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !events.valid |-> track.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== rtl/core/mtep_parse.sv =====
`timescale 1ns / 1ps
// Combinational next-state and record logic for one track byte.
// Depends on mtep_pkg.
module mtep_parse (
  input  mtep_pkg::parse_state_t st,
  input  logic [7:0]             track_byte,
  input  logic                   track_last,
  output mtep_pkg::parse_state_t st_next,
  output logic                   emit,
  output mtep_pkg::event_rec_t   rec
);

  // Drop everything that belongs to the finished event; running status stays.
  function automatic mtep_pkg::parse_state_t clear_event(input mtep_pkg::parse_state_t s);
    mtep_pkg::parse_state_t c;
    c = '0;
    c.phase = mtep_pkg::PH_DELTA;
    c.running_status = s.running_status;
    return c;
  endfunction

  logic [27:0] acc_shift;
  logic        vdone;
  logic        vovf;
  logic [27:0] skip_dec;
  logic [7:0]  s;
  mtep_pkg::parse_state_t nx;

  assign acc_shift = {st.acc[20:0], track_byte[6:0]};
  assign vdone     = !track_byte[7];
  assign vovf      = track_byte[7] &&
                     (({1'b0, st.vcount} + 4'd1) >= 4'(mtep_pkg::VARLEN_MAX));
  assign skip_dec  = st.skip - 28'd1;

  always_comb begin
    nx   = st;
    emit = 1'b0;
    rec  = '0;
    s    = st.current_status;
    case (st.phase)
      mtep_pkg::PH_DELTA: begin
        if (vdone) begin
          nx.held_delta = acc_shift;
          nx.acc = '0;
          nx.vcount = '0;
          nx.phase = mtep_pkg::PH_STATUS;
        end else if (vovf) begin
          emit = 1'b1;
          rec.kind = mtep_pkg::KIND_OVERFLOW;
          nx = clear_event(st);
        end else begin
          nx.acc = acc_shift;
          nx.vcount = st.vcount + 1'b1;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (track_byte[7]) begin
          nx.current_status = track_byte;
          if (track_byte == mtep_pkg::STATUS_META) begin
            nx.running_status = '0;
            nx.phase = mtep_pkg::PH_MTYPE;
          end else if (track_byte == mtep_pkg::STATUS_SYSEX) begin
            nx.running_status = '0;
            nx.phase = mtep_pkg::PH_SYSEX;
          end else begin
            if (track_byte < mtep_pkg::STATUS_SYS) begin
              nx.running_status = track_byte;
            end else if (track_byte < mtep_pkg::STATUS_RT) begin
              nx.running_status = '0;
            end
            if (mtep_pkg::data_needed(track_byte) == 2'd0) begin
              emit = 1'b1;
              rec.kind = mtep_pkg::KIND_SYSTEM;
              rec.delta_time = st.held_delta;
              rec.status = track_byte;
              nx = clear_event(nx);
            end else begin
              nx.phase = mtep_pkg::PH_DATA1;
            end
          end
        end else if (st.running_status == 8'd0) begin
          emit = 1'b1;
          rec.kind = mtep_pkg::KIND_STRAY;
          rec.delta_time = st.held_delta;
          nx = clear_event(st);
        end else begin
          s = st.running_status;
          nx.current_status = s;
          if (mtep_pkg::data_needed(s) == 2'd1) begin
            emit = 1'b1;
            rec.kind = mtep_pkg::kind_of(s);
            rec.delta_time = st.held_delta;
            rec.status = s;
            rec.first_data = track_byte[6:0];
            rec.data_count = 2'd1;
            nx = clear_event(st);
          end else begin
            nx.held_first = track_byte[6:0];
            nx.phase = mtep_pkg::PH_DATA2;
          end
        end
      end
      mtep_pkg::PH_DATA1: begin
        if (mtep_pkg::data_needed(s) == 2'd1) begin
          emit = 1'b1;
          rec.kind = mtep_pkg::kind_of(s);
          rec.delta_time = st.held_delta;
          rec.status = s;
          rec.first_data = track_byte[6:0];
          rec.data_count = 2'd1;
          nx = clear_event(st);
        end else begin
          nx.held_first = track_byte[6:0];
          nx.phase = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        emit = 1'b1;
        rec.kind = mtep_pkg::kind_of(s);
        rec.delta_time = st.held_delta;
        rec.status = s;
        rec.first_data = st.held_first;
        rec.second_data = track_byte[6:0];
        rec.data_count = 2'd2;
        nx = clear_event(st);
      end
      mtep_pkg::PH_MTYPE: begin
        nx.held_meta_type = track_byte;
        nx.acc = '0;
        nx.vcount = '0;
        nx.phase = mtep_pkg::PH_MLEN;
      end
      mtep_pkg::PH_MLEN: begin
        if (vdone) begin
          if (acc_shift == 28'd0) begin
            emit = 1'b1;
            rec.kind = mtep_pkg::KIND_META;
            rec.delta_time = st.held_delta;
            rec.status = mtep_pkg::STATUS_META;
            rec.meta_type = st.held_meta_type;
            nx = clear_event(st);
          end else begin
            nx.acc = acc_shift;
            nx.skip = acc_shift;
            nx.phase = mtep_pkg::PH_MSKIP;
          end
        end else if (vovf) begin
          emit = 1'b1;
          rec.kind = mtep_pkg::KIND_OVERFLOW;
          rec.delta_time = st.held_delta;
          rec.status = mtep_pkg::STATUS_META;
          rec.meta_type = st.held_meta_type;
          nx = clear_event(st);
        end else begin
          nx.acc = acc_shift;
          nx.vcount = st.vcount + 1'b1;
        end
      end
      mtep_pkg::PH_MSKIP: begin
        if (skip_dec == 28'd0) begin
          emit = 1'b1;
          rec.kind = mtep_pkg::KIND_META;
          rec.delta_time = st.held_delta;
          rec.status = mtep_pkg::STATUS_META;
          rec.meta_type = st.held_meta_type;
          rec.meta_length = st.acc;
          nx = clear_event(st);
        end else begin
          nx.skip = skip_dec;
        end
      end
      mtep_pkg::PH_SYSEX: begin
        if (track_byte[7]) begin
          emit = 1'b1;
          rec.kind = mtep_pkg::KIND_SYSEX;
          rec.delta_time = st.held_delta;
          rec.status = mtep_pkg::STATUS_SYSEX;
          nx = clear_event(st);
        end
      end
      default: begin
        nx = clear_event(st);
      end
    endcase

    // The final byte of a track flags an unfinished event and resets everything.
    if (track_last) begin
      if (!emit && !(nx.phase == mtep_pkg::PH_DELTA && nx.vcount == '0 && nx.acc == 28'd0))
      begin
        emit = 1'b1;
        rec = '0;
        rec.kind = mtep_pkg::KIND_TRUNC;
        rec.delta_time = nx.held_delta;
        rec.status = nx.current_status;
      end
      nx = '0;
    end
    st_next = nx;
  end

endmodule
